// ===== sv/dual_protocol_frame_deframer_unit_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef DUAL_PROTOCOL_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define DUAL_PROTOCOL_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define DPFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dpfd assertion failed: %m");

// Condition that must never hold outside reset.
`define DPFD_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dpfd forbidden condition: %m");

`else

`define DPFD_ASSERT(label, clk, rst, prop)
`define DPFD_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== sv/dpfd_pkg.sv =====
// Types and constants of the dual protocol frame deframer.
`default_nettype none

package dpfd_pkg;

   localparam int unsigned FRAME_CAPACITY = 260;
   localparam int unsigned CNT_W          = 9;
   localparam int unsigned LEN_W          = CNT_W + 1;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [LEN_W-1:0] len_type;

   localparam cnt_type FRAME_CAP     = CNT_W'(FRAME_CAPACITY);
   localparam len_type FRAME_CAP_LEN = LEN_W'(FRAME_CAPACITY);

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      PROTO_NONE     = 2'd0,
      PROTO_DISPLAY  = 2'd1,
      PROTO_ACTUATOR = 2'd2
   } proto_type;

   localparam logic [7:0] DISPLAY_SOF0  = 8'h5A;
   localparam logic [7:0] DISPLAY_SOF1  = 8'hA5;
   localparam logic [7:0] ACTUATOR_SOF  = 8'hFF;

   localparam int unsigned FC_EXCEPTION_BIT = 7;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_READ_INPUT    = 8'h04;

   localparam len_type DISPLAY_HDR_LEN = LEN_W'(3);
   localparam len_type ACT_EXC_LEN     = LEN_W'(5);
   localparam len_type ACT_WRITE_LEN   = LEN_W'(8);
   localparam len_type ACT_READ_BASE   = LEN_W'(5);

   localparam logic [15:0] TIMEOUT_RESET = 16'd30;
   localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      cnt_type    byte_index;
      proto_type  byte_protocol;
      logic       frame_done;
      logic       frame_abort;
      proto_type  ended_protocol;
      cnt_type    frame_length;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/dpfd_in_stage.sv =====
// Input register of the deframer.
`default_nettype none

module dpfd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire dpfd_pkg::item_type req_item,
   output logic                   req_stall,
   input  wire logic              advance,
   output logic                   item_valid,
   output dpfd_pkg::item_type     item
);

   logic               valid_ff, valid_in;
   dpfd_pkg::item_type item_ff, item_in;

   // hold the current transaction until the core takes it
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== sv/dpfd_core.sv =====
// Frame state and per-item decode of the deframer.
`default_nettype none
`include "dual_protocol_frame_deframer_unit_defines.svh"

module dpfd_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [15:0]         csr_wr_data,
   input  wire logic                item_go,
   input  wire dpfd_pkg::item_type  item,
   output dpfd_pkg::result_type     result,
   output logic                     result_present
);

   dpfd_pkg::proto_type proto_ff, proto_in;
   dpfd_pkg::cnt_type   rcnt_ff, rcnt_in;
   dpfd_pkg::cnt_type   ecnt_ff, ecnt_in;
   logic [7:0]          sec_ff, sec_in;
   logic [7:0]          thd_ff, thd_in;
   logic [15:0]         sil_ff, sil_in;
   logic [15:0]         timeout_ff, timeout_in;

   dpfd_pkg::proto_type start_proto;
   dpfd_pkg::cnt_type   rcnt_next;
   logic [7:0]          rx;

   assign rx        = item.rx_byte;
   assign rcnt_next = rcnt_ff + dpfd_pkg::cnt_type'(1);

   // a byte that can open a frame
   always_comb begin
      if (rx == dpfd_pkg::DISPLAY_SOF0) begin
         start_proto = dpfd_pkg::PROTO_DISPLAY;
      end else if (rx == dpfd_pkg::ACTUATOR_SOF) begin
         start_proto = dpfd_pkg::PROTO_ACTUATOR;
      end else begin
         start_proto = dpfd_pkg::PROTO_NONE;
      end
   end

   always_comb begin
      logic              restart;
      logic              len_bad;
      dpfd_pkg::len_type len_calc;
      logic [7:0]        sec_eff;
      logic [7:0]        thd_eff;

      proto_in   = proto_ff;
      rcnt_in    = rcnt_ff;
      ecnt_in    = ecnt_ff;
      sec_in     = sec_ff;
      thd_in     = thd_ff;
      sil_in     = sil_ff;
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      result     = '0;
      restart    = 1'b0;
      len_bad    = 1'b0;
      len_calc   = {1'b0, ecnt_ff};
      sec_eff    = sec_ff;
      thd_eff    = thd_ff;

      if (item_go) begin
         if (item.opcode == dpfd_pkg::OP_TICK) begin
            if (sil_ff != dpfd_pkg::SILENCE_MAX) begin
               sil_in = sil_ff + 16'd1;
            end
            // timeout: actuator frames are delivered, display frames dropped
            if (proto_ff != dpfd_pkg::PROTO_NONE && sil_in >= timeout_ff) begin
               result.ended_protocol = proto_ff;
               if (proto_ff == dpfd_pkg::PROTO_ACTUATOR) begin
                  result.frame_done   = 1'b1;
                  result.frame_length = rcnt_ff;
               end else begin
                  result.frame_abort = 1'b1;
               end
               proto_in = dpfd_pkg::PROTO_NONE;
               rcnt_in  = '0;
               ecnt_in  = '0;
            end
         end else if (proto_ff == dpfd_pkg::PROTO_NONE) begin
            restart = 1'b1;
         end else if (rcnt_ff >= dpfd_pkg::FRAME_CAP ||
                      (proto_ff == dpfd_pkg::PROTO_DISPLAY &&
                       rcnt_ff == dpfd_pkg::cnt_type'(1) &&
                       rx != dpfd_pkg::DISPLAY_SOF1)) begin
            // overflow or bad display header: drop and re-examine the byte
            result.frame_abort    = 1'b1;
            result.ended_protocol = proto_ff;
            proto_in = dpfd_pkg::PROTO_NONE;
            rcnt_in  = '0;
            ecnt_in  = '0;
            restart  = 1'b1;
         end else begin
            result.byte_valid    = 1'b1;
            result.data_byte     = rx;
            result.byte_index    = rcnt_ff;
            result.byte_protocol = proto_ff;
            sil_in  = '0;
            rcnt_in = rcnt_next;
            if (rcnt_ff == dpfd_pkg::cnt_type'(1)) begin
               sec_in  = rx;
               sec_eff = rx;
            end
            if (rcnt_ff == dpfd_pkg::cnt_type'(2)) begin
               thd_in  = rx;
               thd_eff = rx;
            end
            if (proto_ff == dpfd_pkg::PROTO_DISPLAY) begin
               if (rcnt_ff == dpfd_pkg::cnt_type'(2)) begin
                  len_calc = dpfd_pkg::DISPLAY_HDR_LEN + {2'b00, rx};
                  len_bad  = (rx == 8'd0) || (len_calc > dpfd_pkg::FRAME_CAP_LEN);
               end
            end else if (rcnt_ff != '0) begin
               // length from the function code, recomputed on every byte
               if (sec_eff[dpfd_pkg::FC_EXCEPTION_BIT]) begin
                  len_calc = dpfd_pkg::ACT_EXC_LEN;
               end else if (sec_eff == dpfd_pkg::FC_WRITE_SINGLE ||
                            sec_eff == dpfd_pkg::FC_WRITE_MULTI) begin
                  len_calc = dpfd_pkg::ACT_WRITE_LEN;
               end else if ((sec_eff == dpfd_pkg::FC_READ_HOLDING ||
                             sec_eff == dpfd_pkg::FC_READ_INPUT) &&
                            rcnt_ff >= dpfd_pkg::cnt_type'(2)) begin
                  len_calc = dpfd_pkg::ACT_READ_BASE + {2'b00, thd_eff};
               end
               len_bad = len_calc > dpfd_pkg::FRAME_CAP_LEN;
            end
            if (len_bad) begin
               // drop the frame; the length byte is not reported
               result.byte_valid     = 1'b0;
               result.data_byte      = '0;
               result.byte_index     = '0;
               result.byte_protocol  = dpfd_pkg::PROTO_NONE;
               result.frame_abort    = 1'b1;
               result.ended_protocol = proto_ff;
               proto_in = dpfd_pkg::PROTO_NONE;
               rcnt_in  = '0;
               ecnt_in  = '0;
            end else begin
               ecnt_in = len_calc[dpfd_pkg::CNT_W-1:0];
               if (len_calc != '0 && {1'b0, rcnt_next} == len_calc) begin
                  result.frame_done     = 1'b1;
                  result.ended_protocol = proto_ff;
                  result.frame_length   = rcnt_next;
                  proto_in = dpfd_pkg::PROTO_NONE;
                  rcnt_in  = '0;
                  ecnt_in  = '0;
               end
            end
         end

         if (restart && start_proto != dpfd_pkg::PROTO_NONE) begin
            proto_in             = start_proto;
            rcnt_in              = dpfd_pkg::cnt_type'(1);
            ecnt_in              = '0;
            sil_in               = '0;
            result.byte_valid    = 1'b1;
            result.data_byte     = rx;
            result.byte_index    = '0;
            result.byte_protocol = start_proto;
         end
      end
   end

   assign result_present = result.byte_valid || result.frame_done || result.frame_abort;

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff   <= dpfd_pkg::PROTO_NONE;
         rcnt_ff    <= '0;
         ecnt_ff    <= '0;
         sec_ff     <= '0;
         thd_ff     <= '0;
         sil_ff     <= '0;
         timeout_ff <= dpfd_pkg::TIMEOUT_RESET;
      end else begin
         proto_ff   <= proto_in;
         rcnt_ff    <= rcnt_in;
         ecnt_ff    <= ecnt_in;
         sec_ff     <= sec_in;
         thd_ff     <= thd_in;
         sil_ff     <= sil_in;
         timeout_ff <= timeout_in;
      end
   end

   `DPFD_NEVER(a_done_and_abort, clock, reset, result.frame_done && result.frame_abort)
   `DPFD_ASSERT(a_count_in_range, clock, reset, rcnt_ff <= dpfd_pkg::FRAME_CAP)
   `DPFD_ASSERT(a_idle_is_empty, clock, reset,
      proto_ff == dpfd_pkg::PROTO_NONE |-> (rcnt_ff == '0 && ecnt_ff == '0))
   `DPFD_ASSERT(a_store_clears_silence, clock, reset,
      (item_go && result.byte_valid) |=> sil_ff == '0)

endmodule

`default_nettype wire

// ===== sv/dpfd_out_stage.sv =====
// Result register of the deframer.
`default_nettype none
`include "dual_protocol_frame_deframer_unit_defines.svh"

module dpfd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire dpfd_pkg::result_type result,
   output logic                      out_ready,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output dpfd_pkg::result_type      rsp
);

   logic                 valid_ff, valid_in;
   dpfd_pkg::result_type rsp_ff, rsp_in;

   // take a new result when empty or when the current one leaves this edge
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   `DPFD_ASSERT(a_result_not_empty, clock, reset,
      valid_ff |-> (rsp_ff.byte_valid || rsp_ff.frame_done || rsp_ff.frame_abort))
   `DPFD_NEVER(a_load_while_blocked, clock, reset, load && !out_ready)

endmodule

`default_nettype wire

// ===== sv/dual_protocol_frame_deframer_unit.sv =====
// Top level of the dual protocol frame deframer.
//
// Usage: req_ carries one transaction per accepted edge (req_valid high,
// req_stall low): either a received serial byte (req_opcode 0, req_rx_byte)
// or a one millisecond tick (req_opcode 1). The block tracks display frames
// (5A A5 len ...) and actuator frames (FF fc ... with length from fc) and
// reports every stored byte with its frame index and kind on rsp_, plus
// frame_done / frame_abort so a downstream buffer can commit or drop it.
// Items that cause nothing (idle bytes, quiet ticks) produce no rsp_ transaction.
// A result reaches rsp_valid through the input register, then the decode into the
// result register.
// Throughput: one item per cycle while rsp_stall is low; the frame state register
// is the only loop, updated in a single pass per item.
// Reset (synchronous, active high) returns to idle with timeout_ticks = 30.
// Write timeout_ticks (csr_wr_en / csr_wr_data) only while idle; not enforced.
// When rsp_stall is high the result register holds; at most one more item
// still enters the input register, after which req_stall rises.
`default_nettype none

module dual_protocol_frame_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_byte_valid,
   output logic [7:0]       rsp_data_byte,
   output logic [8:0]       rsp_byte_index,
   output logic [1:0]       rsp_byte_protocol,
   output logic             rsp_frame_done,
   output logic             rsp_frame_abort,
   output logic [1:0]       rsp_ended_protocol,
   output logic [8:0]       rsp_frame_length,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   dpfd_pkg::item_type   req_item;
   dpfd_pkg::item_type   item;
   dpfd_pkg::result_type result;
   dpfd_pkg::result_type rsp;
   logic                 item_valid;
   logic                 advance;
   logic                 out_ready;
   logic                 result_present;

   assign req_item.opcode  = dpfd_pkg::opcode_type'(req_opcode);
   assign req_item.rx_byte = req_rx_byte;

   // process the held item whenever the result register can take its outcome
   assign advance = item_valid && out_ready;

   dpfd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   dpfd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .item_go        (advance),
      .item           (item),
      .result         (result),
      .result_present (result_present)
   );

   // only items with an outcome become rsp_ transactions
   dpfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result_present),
      .result    (result),
      .out_ready (out_ready),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // unpack the result register onto the ports
   assign rsp_byte_valid     = rsp.byte_valid;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_byte_index     = rsp.byte_index;
   assign rsp_byte_protocol  = rsp.byte_protocol;
   assign rsp_frame_done     = rsp.frame_done;
   assign rsp_frame_abort    = rsp.frame_abort;
   assign rsp_ended_protocol = rsp.ended_protocol;
   assign rsp_frame_length   = rsp.frame_length;

endmodule

`default_nettype wire
